// File: src/trrf_pkg.sv
// ----------------------------------------------------------------------------
// Tap record/replay flasher package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package trrf_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;

  // Pad added to the loop length when replay starts.
  localparam logic [31:0] LOOP_PAD_MS = 32'd10;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_HIGH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LULL_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP   = 3'd5;

  localparam logic [15:0] TAP_HIGH_RST  = 16'd512;
  localparam logic [15:0] TAP_LOW_RST   = 16'd128;
  localparam logic [15:0] LULL_MS_RST   = 16'd2000;
  localparam logic [7:0]  PEAK_RST      = 8'd255;
  localparam logic [7:0]  FLOOR_RST     = 8'd0;
  localparam logic [7:0]  FADE_STEP_RST = 8'd8;

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic load_in;
    logic decide;
    logic div_step;
    logic set_index;
    logic walk;
    logic load_out;
  } trrf_cmd_t;

  typedef struct packed {
    logic tap;
    logic replay;
    logic div_last;
    logic walk_go;
  } trrf_stat_t;

endpackage

// File: src/trrf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/trrf_datapath.sv
// ----------------------------------------------------------------------------
// Tap record/replay flasher datapath
// Configuration registers, tap detector, fade, mode state, tap history,
// serial divider for the replay loop and the output register.
// ----------------------------------------------------------------------------
module trrf_datapath #(
  parameter int HISTORY_DEPTH = trrf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  trrf_pkg::trrf_cmd_t             cmd,
  output trrf_pkg::trrf_stat_t            stat,
  input  logic                            cfg_we,
  input  logic [trrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trrf_pkg::CFG_W-1:0]      cfg_data,
  input  logic [15:0]                     activity_sample,
  input  logic [31:0]                     now_ms,
  output logic [7:0]                      level,
  output logic                            replaying,
  output logic                            buffer_full,
  output logic                            tap_seen
);

  import trrf_pkg::*;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);

  logic [15:0] tap_high_threshold;
  logic [15:0] tap_low_threshold;
  logic [15:0] lull_ms;
  logic [7:0]  peak_brightness;
  logic [7:0]  floor_brightness;
  logic [7:0]  fade_step;

  logic             armed;
  logic             tap;
  logic [31:0]      last_tap_time;
  logic             replay_flag;
  logic [31:0]      switch_time;
  logic [31:0]      loop_length;
  logic [31:0]      loop_index;
  logic [PTR_W-1:0] play_pointer;
  logic [PTR_W-1:0] play_pointer_next;
  logic [PTR_W-1:0] record_pointer;
  logic [7:0]       glow;
  logic [31:0]      now_q;

  logic [31:0]          div_rem;
  logic [31:0]          div_quo;
  logic [31:0]          div_den;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [7:0]  glow_sub;
  logic [7:0]  glow_faded;
  logic [31:0] elapsed;
  logic [31:0] lull32;
  logic [31:0] loop_limit;
  logic [31:0] new_length;
  logic        lull_hit;
  logic [32:0] div_trial;
  logic [32:0] div_diff;
  logic        div_fits;
  logic [31:0] rd_data;
  logic        walk_go;
  logic        hist_we;
  logic [PTR_W-1:0] record_inc;

  assign glow_sub   = (glow > fade_step) ? glow - fade_step : 8'd0;
  assign glow_faded = (glow_sub < floor_brightness) ? floor_brightness : glow_sub;

  assign elapsed    = now_q - switch_time;
  assign lull32     = {16'd0, lull_ms};
  assign loop_limit = (lull32 >= LOOP_PAD_MS) ? lull32 - LOOP_PAD_MS : 32'd0;
  assign new_length = (elapsed < loop_limit) ? 32'd0 : elapsed - lull32 + LOOP_PAD_MS;
  assign lull_hit   = (now_q - last_tap_time) > lull32;

  assign div_trial = {div_rem, div_quo[DIV_W-1]};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_fits  = div_trial >= {1'b0, div_den};

  // After the division, div_rem is the offset into the loop.
  assign walk_go    = (play_pointer < record_pointer) && (div_rem > rd_data);
  assign record_inc = (record_pointer == LAST_SLOT) ? record_pointer : record_pointer + 1'b1;
  assign hist_we    = cmd.decide && !replay_flag && tap;

  // The history is always read at the next play pointer, so during the walk
  // the read data belongs to the current play pointer.
  always_comb begin
    play_pointer_next = play_pointer;
    if (cmd.decide && !replay_flag && lull_hit) begin
      play_pointer_next = '0;
    end
    if (cmd.set_index && (div_quo != loop_index)) begin
      play_pointer_next = '0;
    end
    if (cmd.walk && walk_go) begin
      play_pointer_next = play_pointer + 1'b1;
    end
  end

  trrf_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (record_pointer),
    .wr_data (elapsed),
    .rd_addr (play_pointer_next),
    .rd_data (rd_data)
  );

  assign stat.tap      = tap;
  assign stat.replay   = replay_flag;
  assign stat.div_last = (div_cnt == DIV_CNT_W'(DIV_W - 1));
  assign stat.walk_go  = walk_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_high_threshold <= TAP_HIGH_RST;
      tap_low_threshold  <= TAP_LOW_RST;
      lull_ms            <= LULL_MS_RST;
      peak_brightness    <= PEAK_RST;
      floor_brightness   <= FLOOR_RST;
      fade_step          <= FADE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_HIGH:  tap_high_threshold <= cfg_data;
        CFG_TAP_LOW:   tap_low_threshold  <= cfg_data;
        CFG_LULL_MS:   lull_ms            <= cfg_data;
        CFG_PEAK:      peak_brightness    <= cfg_data[7:0];
        CFG_FLOOR:     floor_brightness   <= cfg_data[7:0];
        CFG_FADE_STEP: fade_step          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b1;
      tap            <= 1'b0;
      last_tap_time  <= '0;
      replay_flag    <= 1'b0;
      switch_time    <= '0;
      loop_length    <= '0;
      loop_index     <= '0;
      play_pointer   <= '0;
      record_pointer <= '0;
      glow           <= '0;
      now_q          <= '0;
      div_rem        <= '0;
      div_quo        <= '0;
      div_den        <= 32'd1;
      div_cnt        <= '0;
      level          <= '0;
      replaying      <= 1'b0;
      buffer_full    <= 1'b0;
      tap_seen       <= 1'b0;
    end else begin
      play_pointer <= play_pointer_next;

      if (cmd.load_in) begin
        now_q <= now_ms;
        glow  <= glow_faded;
        tap   <= armed && (activity_sample > tap_high_threshold);
        if (armed) begin
          if (activity_sample > tap_high_threshold) begin
            armed         <= 1'b0;
            last_tap_time <= now_ms;
          end
        end else if (activity_sample < tap_low_threshold) begin
          armed <= 1'b1;
        end
      end

      if (cmd.decide) begin
        if (replay_flag) begin
          if (tap) begin
            // A tap during replay goes back to recording, without a flash.
            replay_flag    <= 1'b0;
            switch_time    <= now_q;
            record_pointer <= '0;
            loop_length    <= '0;
            loop_index     <= '0;
          end else begin
            loop_length <= (loop_length == 32'd0) ? 32'd1 : loop_length;
            div_den     <= (loop_length == 32'd0) ? 32'd1 : loop_length;
            div_rem     <= '0;
            div_quo     <= elapsed;
            div_cnt     <= '0;
          end
        end else begin
          if (tap) begin
            glow           <= peak_brightness;
            record_pointer <= record_inc;
          end
          if (lull_hit) begin
            replay_flag <= 1'b1;
            switch_time <= now_q;
            loop_length <= new_length;
          end
        end
      end

      if (cmd.div_step) begin
        div_rem <= div_fits ? div_diff[31:0] : div_trial[31:0];
        div_quo <= {div_quo[DIV_W-2:0], div_fits};
        div_cnt <= div_cnt + 1'b1;
      end

      if (cmd.set_index && (div_quo != loop_index)) begin
        loop_index <= div_quo;
      end

      if (cmd.walk && walk_go) begin
        glow <= peak_brightness;
      end

      if (cmd.load_out) begin
        level       <= glow;
        replaying   <= replay_flag;
        buffer_full <= !replay_flag && (record_pointer == LAST_SLOT);
        tap_seen    <= tap;
      end
    end
  end

  a_play_in_range: assert property (@(posedge clk) disable iff (rst)
    replay_flag |-> (play_pointer <= record_pointer))
    else $error("play pointer ran past the recorded taps");

  a_full_only_record: assert property (@(posedge clk) disable iff (rst)
    buffer_full |-> !replaying)
    else $error("buffer_full reported during replay");

endmodule

// File: src/trrf_ctrl.sv
// ----------------------------------------------------------------------------
// Tap record/replay flasher controller
// Sequences one request through decide, divide, index, history walk and output;
// record requests and taps in replay mode go from decide straight to output.
module trrf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output trrf_pkg::trrf_cmd_t  cmd,
  input  trrf_pkg::trrf_stat_t stat
);

  import trrf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_INDEX,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.load_in   = in_valid && (state == S_IDLE);
    cmd.decide    = (state == S_DECIDE);
    cmd.div_step  = (state == S_DIV);
    cmd.set_index = (state == S_INDEX);
    cmd.walk      = (state == S_WALK);
    cmd.load_out  = (state == S_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stat.replay && !stat.tap) begin
            state <= S_DIV;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (!stat.walk_go) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_decides: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (state == S_DECIDE))
    else $error("accepted request did not move to decide");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (out_valid && (state == S_IDLE)))
    else $error("finished request did not reach the output register");

  a_div_to_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && stat.div_last |=> (state == S_INDEX))
    else $error("divider did not hand over after its last step");

  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> ((state == S_WALK) || (state == S_FINISH)))
    else $error("history walk left to an unexpected state");

endmodule

// File: src/tap_record_replay_flasher.sv
// ----------------------------------------------------------------------------
// Tap record/replay flasher
// Detects taps in an activity stream, fades a brightness level, records tap
// times and replays them as a loop after a lull.
//
// Usage:
//   One input request is one frame tick: activity_sample and now_ms, taken
//   when in_valid is high and in_stall is low. Each request gives exactly one
//   result (level, replaying, buffer_full, tap_seen), taken when out_valid is
//   high and out_stall is low.
//   In record mode, and for a tap in replay mode, a request goes from the
//   decide step straight to the output register. Any other replay request
//   first runs the serial divider, which splits the elapsed time into loop
//   count and offset, and then walks the history entries, one per cycle
//   from the single read port of the history memory (at most HISTORY_DEPTH - 1
//   entries are consumed per request).
//   A new request is taken in the cycle after the previous result is loaded,
//   even while that result is still stalled in the output register.
//   Synchronous reset restores all registers to their defaults and empties
//   the output; the history memory is not cleared, since an entry is only
//   read after it has been written. Configuration writes are taken at once.
// ----------------------------------------------------------------------------
module tap_record_replay_flasher #(
  parameter int HISTORY_DEPTH = trrf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    activity_sample,
  input  logic [31:0]                    now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     level,
  output logic                           replaying,
  output logic                           buffer_full,
  output logic                           tap_seen,
  input  logic                           cfg_we,
  input  logic [trrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trrf_pkg::CFG_W-1:0]     cfg_data
);

  import trrf_pkg::*;

  trrf_cmd_t  cmd;
  trrf_stat_t stat;

  trrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  trrf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .activity_sample (activity_sample),
    .now_ms          (now_ms),
    .level           (level),
    .replaying       (replaying),
    .buffer_full     (buffer_full),
    .tap_seen        (tap_seen)
  );

endmodule
